@@ rtl/core/tlv_pkg.sv @@
// Shared types and constants for the control frame deframer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tlv_pkg;

    // Header layout: kind byte, then a big-endian length field
    localparam int LENGTH_BYTES = 4;
    localparam logic [2:0] POS_KIND     = 3'd0;
    localparam logic [2:0] POS_LEN_LAST = 3'(LENGTH_BYTES);
    localparam logic [2:0] POS_PAYLOAD  = 3'(LENGTH_BYTES + 1);

    // Frame kinds
    localparam logic [7:0] KIND_DATA   = 8'd1;
    localparam logic [7:0] KIND_RESIZE = 8'd2;
    localparam logic [7:0] KIND_STOP   = 8'd3;

    // Payload length a resize frame must carry
    localparam logic [31:0] RESIZE_LENGTH = 32'd4;

    // Configuration register indexes and reset values
    localparam logic [1:0] CFG_MAX_PAYLOAD = 2'd0;
    localparam logic [1:0] CFG_DIM_MIN     = 2'd1;
    localparam logic [1:0] CFG_DIM_MAX     = 2'd2;

    localparam logic [16:0] MAX_PAYLOAD_RST = 17'd65536;
    localparam logic [15:0] DIM_MIN_RST     = 16'd2;
    localparam logic [15:0] DIM_MAX_RST     = 16'd1000;

    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_DATA   = 3'd1,
        EV_RESIZE = 3'd2,
        EV_STOP   = 3'd3,
        EV_ERROR  = 3'd4
    } event_t;

    typedef struct packed {
        logic [16:0] max_payload;
        logic [15:0] dim_min;
        logic [15:0] dim_max;
    } cfg_t;

    typedef struct packed {
        event_t      ev;
        logic [7:0]  data_byte;
        logic        frame_end;
        logic [15:0] columns;
        logic [15:0] rows;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/core/tlv_parse.sv @@
// Input register and per-byte frame parser of the deframer.
// Depends on tlv_pkg for frame constants, config and result types.
`timescale 1ns / 1ps
`default_nettype none
module tlv_parse
    import tlv_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] in_byte,
    input  wire cfg_t       cfg,
    input  wire logic       slot_free,
    output logic            res_valid,
    output result_t         res
);

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  kind_reg, kind_next;
    logic [31:0] len_reg, len_next;
    logic [16:0] rem_reg, rem_next;
    logic [31:0] word_reg, word_next;
    logic        err_reg, err_next;

    logic        fire;
    logic [31:0] len_full;
    logic [16:0] rem_dec;
    logic [31:0] word_new;
    logic        cols_ok, rows_ok;

    // Process the held byte when the result register can take its result
    assign fire     = in_valid_reg && slot_free;
    assign in_stall = in_valid_reg && !slot_free;

    // Hold the next byte in the input register
    assign in_valid_next = (in_valid && !in_stall) ? 1'b1 : (fire ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= POS_KIND;
            kind_reg     <= '0;
            len_reg      <= '0;
            rem_reg      <= '0;
            word_reg     <= '0;
            err_reg      <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            pos_reg      <= pos_next;
            kind_reg     <= kind_next;
            len_reg      <= len_next;
            rem_reg      <= rem_next;
            word_reg     <= word_next;
            err_reg      <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
        end
    end

    // Shifted length, payload count and resize word for this byte
    assign len_full = {len_reg[23:0], in_byte_reg};
    assign rem_dec  = rem_reg - 17'd1;
    assign word_new = {word_reg[23:0], in_byte_reg};
    assign cols_ok  = (word_new[31:16] >= cfg.dim_min) && (word_new[31:16] <= cfg.dim_max);
    assign rows_ok  = (word_new[15:0] >= cfg.dim_min) && (word_new[15:0] <= cfg.dim_max);

    // Advance the frame state and form the result
    always_comb
    begin
        pos_next  = pos_reg;
        kind_next = kind_reg;
        len_next  = len_reg;
        rem_next  = rem_reg;
        word_next = word_reg;
        err_next  = err_reg;
        res_valid = 1'b0;
        res       = '0;
        if (fire && !err_reg)
        begin
            if (pos_reg == POS_KIND)
            begin
                kind_next = in_byte_reg;
                len_next  = '0;
                word_next = '0;
                rem_next  = '0;
                pos_next  = 3'd1;
            end
            else if (pos_reg <= POS_LEN_LAST)
            begin
                len_next = len_full;
                if (pos_reg != POS_LEN_LAST)
                begin
                    pos_next = pos_reg + 3'd1;
                end
                else if (len_full > {15'd0, cfg.max_payload})
                begin
                    err_next  = 1'b1;
                    pos_next  = POS_KIND;
                    res_valid = 1'b1;
                    res.ev    = EV_ERROR;
                end
                else
                begin
                    rem_next = len_full[16:0];
                    if (len_full[16:0] == 17'd0)
                    begin
                        pos_next = POS_KIND;
                        if (kind_reg == KIND_STOP)
                        begin
                            res_valid = 1'b1;
                            res.ev    = EV_STOP;
                        end
                        else if (kind_reg != KIND_DATA)
                        begin
                            err_next  = 1'b1;
                            res_valid = 1'b1;
                            res.ev    = EV_ERROR;
                        end
                    end
                    else
                    begin
                        pos_next = POS_PAYLOAD;
                    end
                end
            end
            else
            begin
                // Payload byte, also for any out-of-range position
                rem_next  = rem_dec;
                word_next = word_new;
                if (rem_dec == 17'd0)
                begin
                    pos_next = POS_KIND;
                end
                if (kind_reg == KIND_DATA)
                begin
                    res_valid     = 1'b1;
                    res.ev        = EV_DATA;
                    res.data_byte = in_byte_reg;
                    res.frame_end = (rem_dec == 17'd0);
                end
                else if (rem_dec == 17'd0)
                begin
                    res_valid = 1'b1;
                    if (kind_reg == KIND_RESIZE && len_reg == RESIZE_LENGTH && cols_ok && rows_ok)
                    begin
                        res.ev      = EV_RESIZE;
                        res.columns = word_new[31:16];
                        res.rows    = word_new[15:0];
                    end
                    else
                    begin
                        err_next = 1'b1;
                        res.ev   = EV_ERROR;
                    end
                end
            end
        end
    end

    // Error flag is sticky until reset
    a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |=> err_reg)
        else $error("error flag cleared without reset");

    // Header position stays within the frame layout
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_PAYLOAD)
        else $error("header position out of range");

    // No result after an error, and an error result sets the flag
    a_silent_after_err: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !res_valid)
        else $error("result produced after error");

    a_err_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.ev == EV_ERROR) |=> err_reg)
        else $error("error result without sticky flag");

    // A result is only produced by a processed byte
    a_res_on_fire: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> fire)
        else $error("result without processed byte");

endmodule
`default_nettype wire

@@ rtl/core/tlv_out_reg.sv @@
// Result register of the deframer: holds one result until it is taken.
// Depends on tlv_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none
module tlv_out_reg
    import tlv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t load_res,
    output logic         slot_free,
    output logic         out_valid,
    input  wire logic    out_stall,
    output result_t      out_res
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Free when empty or when the held result leaves this cycle
    assign slot_free = !valid_reg || !out_stall;

    assign valid_next = load ? 1'b1 : ((valid_reg && !out_stall) ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture a new result into the free slot
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule
`default_nettype wire

@@ rtl/core/tlv_control_frame_deframer.sv @@
// Each accepted byte is held in the input register; its result, if any, is loaded into the
// result register once that register is free, and is presented there until it is taken.
// Throughput: one byte per cycle; the parser handles the held byte whenever
// the result register is free. A byte that causes no result still waits for a free result slot.
// Reset (rst_n low, asynchronous) clears frame state and the error flag and
// restores max_payload 65536, dim_min 2, dim_max 1000. Depends on tlv_pkg.
`timescale 1ns / 1ps
`default_nettype none
module tlv_control_frame_deframer
    import tlv_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       event_res,
    output logic [7:0]       data_byte,
    output logic             frame_end,
    output logic [15:0]      columns,
    output logic [15:0]      rows,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    slot_free;
    logic    res_valid;
    result_t res;
    result_t out_res;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MAX_PAYLOAD: cfg_next.max_payload = cfg_data[16:0];
                CFG_DIM_MIN:     cfg_next.dim_min     = cfg_data[15:0];
                CFG_DIM_MAX:     cfg_next.dim_max     = cfg_data[15:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_payload <= MAX_PAYLOAD_RST;
            cfg_reg.dim_min     <= DIM_MIN_RST;
            cfg_reg.dim_max     <= DIM_MAX_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tlv_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .cfg       (cfg_reg),
        .slot_free (slot_free),
        .res_valid (res_valid),
        .res       (res)
    );

    tlv_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .load_res  (res),
        .slot_free (slot_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    // Drive the result fields
    assign event_res = out_res.ev;
    assign data_byte = out_res.data_byte;
    assign frame_end = out_res.frame_end;
    assign columns   = out_res.columns;
    assign rows      = out_res.rows;

endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Self-checking testbench for the control frame deframer: a directed table, then random
// well-formed frames under several register settings, closed by one fatal frame and noise.
// Depends on tlv_pkg and tlv_control_frame_deframer.
`timescale 1ns / 1ps
module tb;
    import tlv_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int BYTE_TARGET  = 1300;
    localparam int PHASE_BYTES  = 180;
    localparam int SETTLE_TICKS = 6;
    localparam int PRINT_CAP    = 20;

    // How a directed row is checked
    typedef enum logic [1:0] {
        ROW_MODEL,
        ROW_NONE,
        ROW_FIXED
    } row_check_t;

    typedef struct {
        logic [7:0] b;
        row_check_t chk;
        result_t    res;
    } step_row_t;

    // Fatal frame shapes for the end of the run
    typedef enum int {
        BAD_LENGTH,
        BAD_RESIZE_LEN,
        BAD_STOP_LEN,
        BAD_KIND,
        BAD_DIMS,
        BAD_DIM_ORDER,
        BAD_EMPTY
    } fault_t;

    localparam result_t NO_RES     = '0;
    localparam result_t STOP_EVT   = {EV_STOP, 8'h00, 1'b0, 16'h0000, 16'h0000};
    localparam result_t DATA_00    = {EV_DATA, 8'h00, 1'b0, 16'h0000, 16'h0000};
    localparam result_t DATA_FF_LAST = {EV_DATA, 8'hFF, 1'b1, 16'h0000, 16'h0000};
    localparam result_t RESIZE_EVT = {EV_RESIZE, 8'h00, 1'b0, 16'd1000, 16'd2};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  event_res;
    logic [7:0]  data_byte;
    logic        frame_end;
    logic [15:0] columns;
    logic [15:0] rows;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    // Predictor copy of the registers and the parser state
    logic [16:0] lim_payload = MAX_PAYLOAD_RST;
    logic [15:0] lo_dim = DIM_MIN_RST;
    logic [15:0] hi_dim = DIM_MAX_RST;
    logic [2:0]  frame_pos = POS_KIND;
    logic [7:0]  kind_acc = 8'h00;
    logic [31:0] len_acc = 32'd0;
    logic [16:0] left_bytes = 17'd0;
    logic [31:0] dims_acc = 32'd0;
    bit          halted = 1'b0;

    result_t     pending_events[$];
    logic [7:0]  frame_bytes[$];
    bit          no_idle = 1'b0;
    int          n_fail = 0;
    int          n_bytes = 0;
    int          n_checked = 0;
    int          n_settings = 0;
    int          n_ev[5] = '{0, 0, 0, 0, 0};
    int          cycle_count = 0;

    step_row_t dir_rows [26] = '{
        // stop frame
        '{8'h03, ROW_MODEL, NO_RES}, '{8'h00, ROW_MODEL, NO_RES},
        '{8'h00, ROW_MODEL, NO_RES}, '{8'h00, ROW_MODEL, NO_RES},
        '{8'h00, ROW_FIXED, STOP_EVT},
        // empty data frame, no result
        '{8'h01, ROW_MODEL, NO_RES}, '{8'h00, ROW_MODEL, NO_RES},
        '{8'h00, ROW_MODEL, NO_RES}, '{8'h00, ROW_MODEL, NO_RES},
        '{8'h00, ROW_NONE, NO_RES},
        // two-byte data frame with extreme bytes
        '{8'h01, ROW_MODEL, NO_RES}, '{8'h00, ROW_MODEL, NO_RES},
        '{8'h00, ROW_MODEL, NO_RES}, '{8'h00, ROW_MODEL, NO_RES},
        '{8'h02, ROW_MODEL, NO_RES}, '{8'h00, ROW_FIXED, DATA_00},
        '{8'hFF, ROW_FIXED, DATA_FF_LAST},
        // resize at both dimension bounds
        '{8'h02, ROW_MODEL, NO_RES}, '{8'h00, ROW_MODEL, NO_RES},
        '{8'h00, ROW_MODEL, NO_RES}, '{8'h00, ROW_MODEL, NO_RES},
        '{8'h04, ROW_MODEL, NO_RES}, '{8'h03, ROW_MODEL, NO_RES},
        '{8'hE8, ROW_MODEL, NO_RES}, '{8'h00, ROW_MODEL, NO_RES},
        '{8'h02, ROW_FIXED, RESIZE_EVT}
    };

    tlv_control_frame_deframer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_byte   (in_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .event_res (event_res),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .columns   (columns),
        .rows      (rows),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                     pending_events.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        out_stall <= !no_idle && ($urandom_range(99) < 23);
    end

    task automatic flag_mismatch(input string what);
        n_fail++;
        if (n_fail <= PRINT_CAP)
            $display("[%0t] check failed: %s", $time, what);
    endtask

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (event_res <= 3'd4)
                n_ev[event_res]++;
            if (pending_events.size() == 0)
                flag_mismatch($sformatf("unexpected result, event %0d", event_res));
            else
            begin
                want = pending_events.pop_front();
                if (event_res !== want.ev)
                    flag_mismatch($sformatf("result %0d event %0d, expected %0d",
                                            n_checked, event_res, want.ev));
                if (data_byte !== want.data_byte)
                    flag_mismatch($sformatf("result %0d data_byte %h, expected %h",
                                            n_checked, data_byte, want.data_byte));
                if (frame_end !== want.frame_end)
                    flag_mismatch($sformatf("result %0d frame_end %b, expected %b",
                                            n_checked, frame_end, want.frame_end));
                if (columns !== want.columns)
                    flag_mismatch($sformatf("result %0d columns %0d, expected %0d",
                                            n_checked, columns, want.columns));
                if (rows !== want.rows)
                    flag_mismatch($sformatf("result %0d rows %0d, expected %0d",
                                            n_checked, rows, want.rows));
            end
            n_checked++;
        end
    end

    function automatic bit dim_fits(input logic [15:0] v);
        return (v >= lo_dim) && (v <= hi_dim);
    endfunction

    // Advance the predicted parser by one byte; hit tells whether a result follows
    task automatic deframe_byte(input logic [7:0] b, output bit hit, output result_t res);
        bit fault;
        fault = 1'b0;
        hit = 1'b0;
        res = '0;
        if (!halted)
        begin
            if (frame_pos == POS_KIND)
            begin
                kind_acc = b;
                len_acc = '0;
                dims_acc = '0;
                left_bytes = '0;
                frame_pos = 3'd1;
            end
            else if (frame_pos <= POS_LEN_LAST)
            begin
                len_acc = {len_acc[23:0], b};
                if (frame_pos < POS_LEN_LAST)
                    frame_pos = frame_pos + 3'd1;
                else if (len_acc > {15'd0, lim_payload})
                    fault = 1'b1;
                else
                begin
                    left_bytes = len_acc[16:0];
                    if (left_bytes != 17'd0)
                        frame_pos = POS_PAYLOAD;
                    else
                    begin
                        // empty payload ends with the header
                        frame_pos = POS_KIND;
                        if (kind_acc == KIND_STOP)
                        begin
                            hit = 1'b1;
                            res.ev = EV_STOP;
                        end
                        else if (kind_acc != KIND_DATA)
                            fault = 1'b1;
                    end
                end
            end
            else
            begin
                left_bytes = left_bytes - 17'd1;
                dims_acc = {dims_acc[23:0], b};
                if (left_bytes == 17'd0)
                    frame_pos = POS_KIND;
                if (kind_acc == KIND_DATA)
                begin
                    hit = 1'b1;
                    res.ev = EV_DATA;
                    res.data_byte = b;
                    res.frame_end = (left_bytes == 17'd0);
                end
                else if (left_bytes == 17'd0)
                begin
                    if (kind_acc == KIND_RESIZE && len_acc == RESIZE_LENGTH &&
                        dim_fits(dims_acc[31:16]) && dim_fits(dims_acc[15:0]))
                    begin
                        hit = 1'b1;
                        res.ev = EV_RESIZE;
                        res.columns = dims_acc[31:16];
                        res.rows = dims_acc[15:0];
                    end
                    else
                        fault = 1'b1;
                end
            end
            // latch the error; later bytes are dropped
            if (fault)
            begin
                halted = 1'b1;
                frame_pos = POS_KIND;
                hit = 1'b1;
                res = '0;
                res.ev = EV_ERROR;
            end
        end
    endtask

    // Offer one byte, idling first at random, and hold it until accepted
    task automatic send_byte(input logic [7:0] b);
        if (!no_idle && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 23);
        end
        in_valid <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_bytes++;
    endtask

    task automatic feed_byte(input logic [7:0] b);
        bit      hit;
        result_t res;
        send_byte(b);
        deframe_byte(b, hit, res);
        if (hit)
            pending_events.push_back(res);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            feed_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    // Drop valid, wait out all results, then let the pipeline settle
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    // Write all three registers; unused upper data bits carry random junk
    task automatic write_cfg(input logic [16:0] mp, input logic [15:0] lo,
                             input logic [15:0] hi);
        logic [1:0]  idx [3];
        logic [31:0] val [3];
        idx = '{CFG_MAX_PAYLOAD, CFG_DIM_MIN, CFG_DIM_MAX};
        val[0] = ($urandom() & 32'hFFFE_0000) | {15'd0, mp};
        val[1] = ($urandom() & 32'hFFFF_0000) | {16'd0, lo};
        val[2] = ($urandom() & 32'hFFFF_0000) | {16'd0, hi};
        for (int i = 0; i < 3; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx[i])
                CFG_MAX_PAYLOAD: lim_payload = val[i][16:0];
                CFG_DIM_MIN:     lo_dim = val[i][15:0];
                CFG_DIM_MAX:     hi_dim = val[i][15:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
        n_settings++;
    endtask

    task automatic push_header(input logic [7:0] k, input logic [31:0] len);
        frame_bytes.push_back(k);
        frame_bytes.push_back(len[31:24]);
        frame_bytes.push_back(len[23:16]);
        frame_bytes.push_back(len[15:8]);
        frame_bytes.push_back(len[7:0]);
    endtask

    // Pick a dimension inside the current bounds, often at a bound
    function automatic logic [15:0] pick_dim();
        int unsigned s;
        s = $urandom_range(3);
        if (s == 0)
            return lo_dim;
        if (s == 1)
            return hi_dim;
        return 16'($urandom_range(hi_dim, lo_dim));
    endfunction

    // Queue one well-formed frame that the current settings accept
    task automatic random_frame();
        int unsigned pick;
        int unsigned len;
        logic [15:0] c;
        logic [15:0] r;
        pick = $urandom_range(99);
        if (pick < 12)
            push_header(KIND_STOP, 32'd0);
        else if (pick < 35 && lim_payload >= 17'd4)
        begin
            c = pick_dim();
            r = pick_dim();
            push_header(KIND_RESIZE, RESIZE_LENGTH);
            frame_bytes.push_back(c[15:8]);
            frame_bytes.push_back(c[7:0]);
            frame_bytes.push_back(r[15:8]);
            frame_bytes.push_back(r[7:0]);
        end
        else
        begin
            // mostly short payloads, a few longer ones
            pick = $urandom_range(99);
            if (pick < 80)
                len = $urandom_range(12, 0);
            else if (pick < 95)
                len = $urandom_range(64, 13);
            else
                len = $urandom_range(300, 65);
            if (len > lim_payload)
                len = lim_payload;
            push_header(KIND_DATA, len);
            repeat (len)
            begin
                pick = $urandom_range(9);
                frame_bytes.push_back(pick == 0 ? 8'h00 : pick == 1 ? 8'hFF : 8'($urandom()));
            end
        end
    endtask

    initial
    begin
        bit          hit;
        result_t     res;
        int          phase;
        int          phase_start;
        logic [15:0] lo;
        logic [15:0] hi;
        logic [15:0] off_dim;
        logic [31:0] len;
        fault_t      fault;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table at the reset settings
        foreach (dir_rows[i])
        begin
            send_byte(dir_rows[i].b);
            deframe_byte(dir_rows[i].b, hit, res);
            case (dir_rows[i].chk)
                ROW_MODEL: if (hit) pending_events.push_back(res);
                ROW_FIXED: pending_events.push_back(dir_rows[i].res);
                default: ;
            endcase
        end
        drain();

        // Random well-formed frames, one register setting per phase
        phase = 0;
        while (n_bytes < BYTE_TARGET)
        begin
            case (phase)
                0: write_cfg(MAX_PAYLOAD_RST, 16'd0, 16'hFFFF);
                1:
                begin
                    lo = 16'($urandom());
                    hi = 16'($urandom_range(65535, lo));
                    write_cfg(17'd0, lo, hi);
                end
                2:
                begin
                    lo = 16'($urandom());
                    write_cfg(17'($urandom_range(40, 1)), lo, lo);
                end
                3: write_cfg(17'($urandom_range(65536, 4)), 16'hFFFF, 16'hFFFF);
                4: write_cfg(17'd65535, 16'd0, 16'd0);
                default:
                begin
                    lo = 16'($urandom());
                    hi = 16'($urandom_range(65535, lo));
                    write_cfg(17'($urandom_range(65536, 0)), lo, hi);
                end
            endcase
            // one phase runs with no idling on either side
            no_idle = (phase == 2);
            if (phase == 2)
            begin
                // data frame exactly at the length limit
                push_header(KIND_DATA, {15'd0, lim_payload});
                repeat (lim_payload) frame_bytes.push_back(8'($urandom()));
                send_frame();
            end
            phase_start = n_bytes;
            while (n_bytes - phase_start < PHASE_BYTES)
            begin
                random_frame();
                send_frame();
            end
            drain();
            phase++;
        end
        no_idle = 1'b0;

        // An error is sticky until reset, so only one fatal frame closes the run
        fault = fault_t'($urandom_range(6));
        if (fault == BAD_DIM_ORDER)
        begin
            lo = 16'($urandom_range(65535, 1));
            hi = 16'($urandom_range(lo - 1, 0));
        end
        else
        begin
            lo = 16'($urandom_range(30000, 1));
            hi = 16'($urandom_range(65534, lo));
        end
        write_cfg(17'($urandom_range(65536, 16)), lo, hi);
        case (fault)
            BAD_LENGTH:
            begin
                len = $urandom_range(1) ? 32'hFFFF_FFFF
                                        : {15'd0, lim_payload} + 32'd1 + $urandom_range(5);
                push_header(8'($urandom()), len);
            end
            BAD_RESIZE_LEN:
            begin
                len = $urandom_range(1) ? 32'd3 : 32'd5 + $urandom_range(6);
                push_header(KIND_RESIZE, len);
                repeat (len) frame_bytes.push_back(8'($urandom()));
            end
            BAD_STOP_LEN:
            begin
                len = $urandom_range(8, 1);
                push_header(KIND_STOP, len);
                repeat (len) frame_bytes.push_back(8'($urandom()));
            end
            BAD_KIND:
            begin
                len = $urandom_range(8, 0);
                push_header($urandom_range(1) ? 8'h00 : 8'($urandom_range(255, 4)), len);
                repeat (len) frame_bytes.push_back(8'($urandom()));
            end
            BAD_DIMS:
            begin
                off_dim = $urandom_range(1) ? lo - 16'd1 : hi + 16'd1;
                push_header(KIND_RESIZE, RESIZE_LENGTH);
                if ($urandom_range(1))
                begin
                    frame_bytes.push_back(off_dim[15:8]);
                    frame_bytes.push_back(off_dim[7:0]);
                    frame_bytes.push_back(lo[15:8]);
                    frame_bytes.push_back(lo[7:0]);
                end
                else
                begin
                    frame_bytes.push_back(lo[15:8]);
                    frame_bytes.push_back(lo[7:0]);
                    frame_bytes.push_back(off_dim[15:8]);
                    frame_bytes.push_back(off_dim[7:0]);
                end
            end
            BAD_DIM_ORDER:
            begin
                push_header(KIND_RESIZE, RESIZE_LENGTH);
                repeat (4) frame_bytes.push_back(8'($urandom()));
            end
            default: push_header(KIND_RESIZE, 32'd0);
        endcase
        // noise after the error must be dropped silently
        repeat (24) frame_bytes.push_back(8'($urandom()));
        send_frame();
        drain();

        $display("covered %0d bytes under %0d register settings, fatal frame shape %s",
                 n_bytes, n_settings, fault.name());
        $display("checked %0d results: %0d data, %0d resize, %0d stop, %0d error",
                 n_checked, n_ev[EV_DATA], n_ev[EV_RESIZE], n_ev[EV_STOP], n_ev[EV_ERROR]);
        if (n_fail == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
